>>> design/mlfq_pkg.sv
// Package for the multilevel feedback tick scheduler: sizes, the job record
// kept in the level FIFO memory, and address helpers. Has no dependencies.
`default_nettype none

package mlfq_pkg;

    // Sizing of the feedback levels and of each level FIFO.
    localparam int LEVELS     = 4;
    localparam int FIFO_DEPTH = 16;

    // Fixed field widths of the request and result payloads.
    localparam int ID_W      = 8;
    localparam int SVC_W     = 8;
    localparam int LVL_OUT_W = 2;

    // Derived widths.
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_DEPTH = LEVELS * FIFO_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // One waiting job: identifier, total service and banked ticks.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SVC_W-1:0] service;
        logic [SVC_W-1:0] done;
    } job_t;

    // Memory address of slot ptr in the FIFO of level lvl.
    function automatic logic [ADDR_W-1:0] job_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [PTR_W-1:0] ptr);
        return ADDR_W'(int'(lvl) * FIFO_DEPTH + int'(ptr));
    endfunction

    // Circular pointer advance with wrap at the FIFO depth.
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W:0] inc;
        inc = {1'b0, ptr} + (PTR_W+1)'(1);
        return (inc == (PTR_W+1)'(FIFO_DEPTH)) ? '0 : inc[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/mlfq_arrive_if.sv
// Request channel of the scheduler: one tick with an optional arriving job.
// Depends on mlfq_pkg for the field widths.
`default_nettype none

interface mlfq_arrive_if;
    logic                         valid;
    logic                         ready;
    logic                         arrive_valid;
    logic [mlfq_pkg::ID_W-1:0]    arrive_id;
    logic [mlfq_pkg::SVC_W-1:0]   arrive_service;

    modport source (output valid, output arrive_valid, output arrive_id,
                    output arrive_service, input ready);
    modport sink   (input valid, input arrive_valid, input arrive_id,
                    input arrive_service, output ready);
endinterface

`default_nettype wire

>>> design/mlfq_run_if.sv
// Result channel of the scheduler: the job holding the processor in a tick.
// Depends on mlfq_pkg for the field widths.
`default_nettype none

interface mlfq_run_if;
    logic                           valid;
    logic                           ready;
    logic                           running_valid;
    logic [mlfq_pkg::ID_W-1:0]      running_id;
    logic [mlfq_pkg::LVL_OUT_W-1:0] running_level;
    logic                           dropped;

    modport source (output valid, output running_valid, output running_id,
                    output running_level, output dropped, input ready);
    modport sink   (input valid, input running_valid, input running_id,
                    input running_level, input dropped, output ready);
endinterface

`default_nettype wire

>>> design/multilevel_feedback_tick_scheduler.sv
// Multilevel feedback queue scheduler advanced one tick per request.
// Depends on mlfq_pkg, mlfq_arrive_if and mlfq_run_if.
//
// Usage:
//   Each request on the arrive channel is one scheduler tick; it may carry a
//   new job (id, service ticks) that joins the level-0 FIFO. For every request
//   exactly one result leaves on the result channel: the job that holds the
//   processor during that tick (or idle), the level it was taken from, and a
//   flag for a job lost to a full FIFO.
//   All waiting jobs of all levels live in one synchronous memory with one
//   write and one read port. A tick walks through the sequence: arrival push
//   and slice check, demotion push, pick of the next job, memory read, result.
//   The memory read step is taken only when a new job is read from memory;
//   the next request is taken once the result sits in the output register.
//   If the receiver stalls, a finished result waits in the output register
//   and the next tick is accepted and processed; it waits for that register
//   before writing its own result.
//   Reset clears the processor, every FIFO pointer and fill count, and the
//   output register. The memory is not cleared: entries are read only after
//   they were written.
`default_nettype none

module multilevel_feedback_tick_scheduler (
    input  logic         clk,
    input  logic         rst_n,
    mlfq_arrive_if.sink  arrive,
    mlfq_run_if.source   result
);
    import mlfq_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DEMOTE, S_PICK, S_LOAD, S_OUT} state_t;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);
    localparam logic [SVC_W-1:0] TICK_MAX = '1;

    state_t               state_reg;

    // Per-level FIFO control.
    logic [PTR_W-1:0]     head_reg [LEVELS];
    logic [PTR_W-1:0]     tail_reg [LEVELS];
    logic [CNT_W-1:0]     fill_reg [LEVELS];

    // Running job.
    logic                 run_valid_reg;
    logic [ID_W-1:0]      run_id_reg;
    logic [SVC_W-1:0]     run_service_reg;
    logic [SVC_W-1:0]     run_done_reg;
    logic [SVC_W-1:0]     run_elapsed_reg;
    logic [LVL_W-1:0]     run_level_reg;

    logic                 demote_reg;
    logic                 dropped_reg;

    // Output register.
    logic                 out_valid_reg;
    logic                 out_run_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [LVL_OUT_W-1:0] out_level_reg;
    logic                 out_dropped_reg;

    // Job memory.
    job_t                 job_mem [MEM_DEPTH];
    job_t                 rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    job_t                 mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;

    logic                 accept;
    logic                 push0;
    logic                 level0_full;
    logic                 any_waiting;
    logic [SVC_W:0]       used;
    logic                 finished;
    logic                 top;
    logic [SVC_W:0]       slice_lim;
    logic                 in_slice;
    logic                 expire;
    logic [LVL_W-1:0]     demote_lvl;
    logic                 demote_full;
    logic                 demote_push;
    logic                 pick_found;
    logic [LVL_W-1:0]     pick_lvl;
    logic                 pick_go;
    logic                 out_free;

    // Handshake.
    assign arrive.ready         = (state_reg == S_IDLE);
    assign accept               = arrive.valid && (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.running_valid = out_run_valid_reg;
    assign result.running_id    = out_id_reg;
    assign result.running_level = out_level_reg;
    assign result.dropped       = out_dropped_reg;
    assign out_free             = !out_valid_reg || result.ready;

    // Arrival push into level 0.
    assign level0_full = (fill_reg[0] == FULL_CNT);
    assign push0       = accept && arrive.arrive_valid && !level0_full;

    // Any job waiting after this tick's arrival.
    always_comb
    begin
        any_waiting = push0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (fill_reg[l] != '0)
            begin
                any_waiting = 1'b1;
            end
        end
    end

    // Slice and finish checks of the running job.
    assign used      = {1'b0, run_done_reg} + {1'b0, run_elapsed_reg};
    assign finished  = (used >= {1'b0, run_service_reg});
    assign top       = (run_level_reg == LVL_W'(LEVELS - 1));
    assign slice_lim = (SVC_W+1)'(1) << run_level_reg;
    assign in_slice  = top || ({1'b0, run_elapsed_reg} < slice_lim);
    assign expire    = run_valid_reg && (finished || !in_slice);

    // Demotion push into the next level.
    assign demote_lvl  = run_level_reg + LVL_W'(1);
    assign demote_full = (fill_reg[demote_lvl] == FULL_CNT);
    assign demote_push = (state_reg == S_DEMOTE) && demote_reg && !demote_full;

    // Lowest non-empty level.
    always_comb
    begin
        pick_found = 1'b0;
        pick_lvl   = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (fill_reg[l] != '0)
            begin
                pick_found = 1'b1;
                pick_lvl   = LVL_W'(l);
            end
        end
    end
    assign pick_go = (state_reg == S_PICK) && !run_valid_reg && pick_found;

    // Memory port selection.
    always_comb
    begin
        mem_we    = push0 || demote_push;
        mem_waddr = job_addr(demote_lvl, tail_reg[demote_lvl]);
        mem_wdata = '{id: run_id_reg, service: run_service_reg, done: run_done_reg};
        if (push0)
        begin
            mem_waddr = job_addr('0, tail_reg[0]);
            mem_wdata = '{id: arrive.arrive_id, service: arrive.arrive_service,
                          done: '0};
        end
        mem_raddr = job_addr(pick_lvl, head_reg[pick_lvl]);
    end

    // Job memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            job_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= job_mem[mem_raddr];
    end

    // Tick sequencer, FIFO control, running job and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                fill_reg[l] <= '0;
            end
            run_valid_reg     <= 1'b0;
            run_id_reg        <= '0;
            run_service_reg   <= '0;
            run_done_reg      <= '0;
            run_elapsed_reg   <= '0;
            run_level_reg     <= '0;
            demote_reg        <= 1'b0;
            dropped_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_run_valid_reg <= 1'b0;
            out_id_reg        <= '0;
            out_level_reg     <= '0;
            out_dropped_reg   <= 1'b0;
        end
        else
        begin
            // A taken result leaves unless a new one is written in its place.
            if (result.ready && !((state_reg == S_OUT) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        // Arrival into level 0, or drop on a full FIFO.
                        dropped_reg <= arrive.arrive_valid && level0_full;
                        demote_reg  <= 1'b0;
                        if (push0)
                        begin
                            tail_reg[0] <= ptr_next(tail_reg[0]);
                            fill_reg[0] <= fill_reg[0] + CNT_W'(1);
                        end
                        // Slice end: bank work, then finish, demote or restart.
                        if (expire)
                        begin
                            run_done_reg <= used[SVC_W-1:0];
                            if (finished)
                            begin
                                run_valid_reg <= 1'b0;
                            end
                            else if (any_waiting)
                            begin
                                demote_reg    <= 1'b1;
                                run_valid_reg <= 1'b0;
                            end
                            else
                            begin
                                run_elapsed_reg <= '0;
                            end
                        end
                        state_reg <= S_DEMOTE;
                    end
                end

                S_DEMOTE:
                begin
                    if (demote_reg && demote_full)
                    begin
                        dropped_reg <= 1'b1;
                    end
                    if (demote_push)
                    begin
                        tail_reg[demote_lvl] <= ptr_next(tail_reg[demote_lvl]);
                        fill_reg[demote_lvl] <= fill_reg[demote_lvl] + CNT_W'(1);
                    end
                    state_reg <= S_PICK;
                end

                S_PICK:
                begin
                    // The memory read of the chosen head is issued here.
                    if (pick_go)
                    begin
                        head_reg[pick_lvl] <= ptr_next(head_reg[pick_lvl]);
                        fill_reg[pick_lvl] <= fill_reg[pick_lvl] - CNT_W'(1);
                        run_level_reg      <= pick_lvl;
                        state_reg          <= S_LOAD;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end

                S_LOAD:
                begin
                    run_valid_reg   <= 1'b1;
                    run_id_reg      <= rd_data_reg.id;
                    run_service_reg <= rd_data_reg.service;
                    run_done_reg    <= rd_data_reg.done;
                    run_elapsed_reg <= '0;
                    state_reg       <= S_OUT;
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_run_valid_reg <= run_valid_reg;
                        out_id_reg        <= run_valid_reg ? run_id_reg : '0;
                        out_level_reg     <= run_valid_reg ?
                                             LVL_OUT_W'(run_level_reg) : '0;
                        out_dropped_reg   <= dropped_reg;
                        if (run_valid_reg && (run_elapsed_reg != TICK_MAX))
                        begin
                            run_elapsed_reg <= run_elapsed_reg + SVC_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
